@@ src/fro_pkg.sv @@
package fro_pkg;

  localparam int VALUE_W     = 64;
  localparam int BW_W        = 7;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 3;
  localparam int ROOM_W      = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [BW_W-1:0] MAX_KEEP_WIDTH = 7'd64;

  typedef enum logic [0:0] {
    REG_FRAME_BASE = 1'b0,
    REG_KEEP_WIDTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_in;
    logic                      is_null;
    logic                      last_item;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_byte;
  } result_t;

  typedef struct packed {
    logic [VALUE_W-1:0] delta;
    logic [BW_W-1:0]    rem;
    logic               last;
  } entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

@@ src/fro_front.sv @@
module fro_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  fro_pkg::cfg_reg_t             cfg_index,
  input  logic [fro_pkg::VALUE_W-1:0]   cfg_data,
  input  logic                          item_valid,
  input  fro_pkg::item_t                item,
  output logic                          item_stall,
  input  fro_pkg::queue_status_t        q_status,
  output logic                          fe_valid,
  output fro_pkg::entry_t               fe_entry
);
  import fro_pkg::*;

  logic [VALUE_W-1:0] frame_base;
  logic [BW_W-1:0]    keep_width;
  logic [BW_W-1:0]    eff_width;
  logic [VALUE_W-1:0] delta;
  logic [VALUE_W-1:0] mask;
  logic               take;
  entry_t             fe_entry_next;

  assign item_stall = fe_valid && q_status.full;
  assign take       = item_valid && !item_stall;

  always_comb begin
    eff_width = (keep_width > MAX_KEEP_WIDTH) ? MAX_KEEP_WIDTH : keep_width;
    delta     = item.is_null ? '0 : (VALUE_W'(item.value_in) - frame_base);
    if (eff_width == MAX_KEEP_WIDTH) begin
      mask = '1;
    end else begin
      mask = (VALUE_W'(1) << eff_width[5:0]) - VALUE_W'(1);
    end
    fe_entry_next.delta = delta & mask;
    fe_entry_next.rem   = eff_width;
    fe_entry_next.last  = item.last_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
      keep_width <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_BASE: frame_base <= cfg_data;
        REG_KEEP_WIDTH: keep_width <= cfg_data[BW_W-1:0];
        default:        frame_base <= frame_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else if (take) begin
      fe_valid <= 1'b1;
    end else if (!q_status.full) begin
      fe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fe_entry <= fe_entry_next;
    end
  end

endmodule

@@ src/fro_queue.sv @@
module fro_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  fro_pkg::entry_t        push_entry,
  input  logic                   pop,
  output fro_pkg::entry_t        head,
  output fro_pkg::queue_status_t status
);
  import fro_pkg::*;

  entry_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ src/fro_back.sv @@
module fro_back (
  input  logic                   clk,
  input  logic                   rst,
  input  fro_pkg::queue_status_t q_status,
  input  fro_pkg::entry_t        head,
  output logic                   pop,
  output logic                   result_valid,
  output fro_pkg::result_t       result,
  input  logic                   result_stall
);
  import fro_pkg::*;

  logic               busy;
  entry_t             cur;
  logic [CNT_W-1:0]   part_cnt;
  logic [CNT_W+3:0]   part_bits;

  entry_t             src;
  logic               have;
  logic               advance;
  logic               step;
  logic [ROOM_W-1:0]  room;
  logic [ROOM_W-1:0]  new_cnt;
  logic [BYTE_W-1:0]  shifted;
  logic [BYTE_W-1:0]  merged;
  logic               emit;
  logic               mark;
  logic               done;
  logic [BW_W-1:0]    rem_next;
  logic [VALUE_W-1:0] delta_next;
  logic [BYTE_W-2:0]  bits_next;
  logic [CNT_W-1:0]   cnt_next;

  always_comb begin
    advance    = !result_valid || !result_stall;
    src        = busy ? cur : head;
    have       = busy || !q_status.empty;
    step       = advance && have;
    pop        = step && !busy;
    room       = ROOM_W'(BYTE_W) - ROOM_W'(part_cnt);
    shifted    = src.delta[BYTE_W-1:0] << part_cnt;
    merged     = {1'b0, part_bits[BYTE_W-2:0]} | shifted;
    new_cnt    = ROOM_W'(part_cnt) + src.rem[ROOM_W-1:0];
    rem_next   = src.rem;
    delta_next = src.delta;
    bits_next  = '0;
    cnt_next   = '0;
    emit       = 1'b0;
    mark       = 1'b0;
    done       = 1'b1;
    if (src.rem >= BW_W'(room)) begin
      emit       = 1'b1;
      mark       = src.last && (src.rem == BW_W'(room));
      rem_next   = src.rem - BW_W'(room);
      delta_next = src.delta >> room;
      done       = (rem_next == '0);
    end else if (src.last) begin
      emit = (new_cnt != '0);
      mark = 1'b1;
    end else begin
      bits_next = merged[BYTE_W-2:0];
      cnt_next  = new_cnt[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      part_bits    <= '0;
      part_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (step) begin
        busy      <= !done;
        part_bits <= bits_next;
        part_cnt  <= cnt_next;
      end
      if (advance) begin
        result_valid <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !done) begin
      cur.delta <= delta_next;
      cur.rem   <= rem_next;
      cur.last  <= src.last;
    end
    if (step && emit) begin
      result.packed_byte <= merged;
      result.last_byte   <= mark;
    end
  end

endmodule

@@ src/frame_of_reference_bit_packer.sv @@
// Order: a taken item is held in the front stage register, then written into the queue, and
// the back stage packs it into the result register. Throughput: one result byte per cycle
// while result_stall is low and items wait; a non-last item's tail below a byte is held over.
// A two-entry queue lets new items be taken while earlier ones are still packed.
// Reset (rst, synchronous, active high) clears the frame base, the kept width, held bits,
// the queue and all valid flags; no clearing pass is needed afterwards.
module frame_of_reference_bit_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  fro_pkg::cfg_reg_t           cfg_index,
  input  logic [fro_pkg::VALUE_W-1:0] cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  fro_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output fro_pkg::result_t            result
);
  import fro_pkg::*;

  logic          fe_valid;
  entry_t        fe_entry;
  logic          q_push;
  logic          q_pop;
  entry_t        q_head;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;
  assign q_push    = fe_valid && !q_status.full;

  fro_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .q_status   (q_status),
    .fe_valid   (fe_valid),
    .fe_entry   (fe_entry)
  );

  fro_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (fe_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  fro_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty together");

  a_take_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> fe_valid)
    else $error("accepted word not held in front stage");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule
